// ----- design/sbe_pkg.sv -----
// Shared types and constants for the stack bytecode execute unit.
package sbe_pkg;

  localparam int OpW = 5;
  localparam int DataW = 32;
  localparam int VarIdxW = 4;
  localparam int BlockW = 8;
  localparam int IpW = 12;
  localparam int StatusW = 3;
  localparam int MaxOut = 32;
  localparam int BlockCount = 1 << BlockW;
  localparam int BlockLength = 1 << IpW;

  typedef enum logic [OpW-1:0] {
    OP_ILOAD   = 5'd0,
    OP_ICONST  = 5'd1,
    OP_ISTORE  = 5'd2,
    OP_IADD    = 5'd3,
    OP_ISUB    = 5'd4,
    OP_IMUL    = 5'd5,
    OP_IDIV    = 5'd6,
    OP_ILT     = 5'd7,
    OP_IAND    = 5'd8,
    OP_IOR     = 5'd9,
    OP_INOT    = 5'd10,
    OP_GOTO    = 5'd11,
    OP_IFFALSE = 5'd12,
    OP_CALL    = 5'd13,
    OP_RETURN  = 5'd14,
    OP_PRINT   = 5'd15,
    OP_STOP    = 5'd16
  } opcode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_CALL_DEPTH = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_RESULT,
    S_PRINT_READ,
    S_PRINT_OUT
  } state_t;

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic [DataW-1:0]   immediate;
    logic [VarIdxW-1:0] var_index;
    logic [BlockW-1:0]  target_block;
  } in_item_t;

  typedef struct packed {
    logic [BlockW-1:0]  next_block;
    logic [IpW-1:0]     next_ip;
    logic               print_valid;
    logic [DataW-1:0]   print_value;
    logic [StatusW-1:0] status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

endpackage

// ----- design/sbe_stream_if.sv -----
// Valid/ready channel carrying one packed payload.
interface sbe_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/sbe_divider.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle.
module sbe_divider
  import sbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic             done,
  output logic [DataW-1:0] quotient
);

  logic [DataW-1:0] rem, quo, dsr;
  logic [5:0] count;
  logic busy, neg;
  logic [DataW:0] trial;
  logic [DataW-1:0] rem_sh;

  assign rem_sh = {rem[DataW-2:0], quo[DataW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        count <= 6'd0;
        neg <= ctrl.neg;
        rem <= '0;
        quo <= dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
        dsr <= divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy) begin
        if (trial[DataW]) begin
          rem <= rem_sh;
          quo <= {quo[DataW-2:0], 1'b0};
        end else begin
          rem <= trial[DataW-1:0];
          quo <= {quo[DataW-2:0], 1'b1};
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

// ----- design/stack_bytecode_execute_unit_core.sv -----
// Top level: stack machine instruction executor.
// Result after read and execute; multiply waits on a product register, divide on the divider.
// Print of n values: each value passes a print-read and a print-out state before its beat.
// One instruction at a time, taken only in idle (read, execute, result, idle).
// Reset: synchronous, clears stack count, frame level, block, pointer and valid bits.
// No clearing pass; memories hold garbage until written.
module stack_bytecode_execute_unit_core
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int VAR_COUNT = 16,
  parameter int CALL_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  sbe_stream_if.sink   in_ch,
  sbe_stream_if.source out_ch
);

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SaW = $clog2(STACK_DEPTH);
  localparam int LvW = $clog2(CALL_DEPTH + 1);
  localparam int CdW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int Slots = (CALL_DEPTH + 1) * VAR_COUNT;
  localparam int SlW = $clog2(Slots);

  in_item_t item;
  out_item_t res;
  state_t state, state_next;

  logic [DataW-1:0] stack_mem [STACK_DEPTH];
  logic [DataW-1:0] var_mem [Slots];
  logic [BlockW-1:0] rblk_mem [CALL_DEPTH];
  logic [IpW-1:0] rip_mem [CALL_DEPTH];
  logic [Slots-1:0] written;

  logic [SpW-1:0] sp;
  logic [LvW-1:0] level;
  logic [BlockW-1:0] cur_block;
  logic [IpW-1:0] ip;

  logic [DataW-1:0] top, second, var_rd;
  logic var_ok;
  logic [BlockW-1:0] rblk_rd;
  logic [IpW-1:0] rip_rd;
  logic [SpW-1:0] print_left;
  logic out_valid;

  logic [DataW-1:0] a_val, b_val, result;
  logic [DataW-1:0] prod;
  logic [SlW-1:0] slot;
  logic [BlockW-1:0] tgt;
  logic [IpW-1:0] ip_inc;
  div_ctrl_t dctl;
  logic div_done;
  logic [DataW-1:0] div_q;
  logic vi_in;
  logic print_go;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = res;

  assign tgt = BlockW'(32'(item.target_block) % BlockCount);
  assign ip_inc = IpW'((32'(ip) + 32'd1) % BlockLength);
  assign vi_in = 32'(item.var_index) < VAR_COUNT;
  assign slot = SlW'(32'(level) * VAR_COUNT + 32'(item.var_index));
  assign a_val = second;
  assign b_val = top;

  assign print_go = (state == S_EXEC) && (item.opcode == OP_PRINT) && (sp != '0)
                    && !top[DataW-1] && (top != '0)
                    && (top <= 32'(sp - SpW'(1))) && (top <= 32'(MaxOut));

  sbe_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctl), .dividend(a_val), .divisor(b_val),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    dctl.start = (state == S_EXEC) && (item.opcode == OP_IDIV) && (sp >= SpW'(2))
                 && (top != '0);
    dctl.neg = a_val[DataW-1] ^ b_val[DataW-1];
  end

  // memory reads: top, second, variable, return entries
  always_ff @(posedge clk) begin
    if (state == S_READ || state == S_PRINT_READ) begin
      top <= stack_mem[SaW'(sp - SpW'(1))];
      second <= stack_mem[SaW'(sp - SpW'(2))];
      var_rd <= var_mem[slot];
      var_ok <= written[slot] && vi_in;
      rblk_rd <= rblk_mem[CdW'(level - LvW'(1))];
      rip_rd <= rip_mem[CdW'(level - LvW'(1))];
    end
  end

  always_ff @(posedge clk) prod <= a_val * b_val;

  always_comb begin
    unique case (item.opcode)
      OP_IADD: result = a_val + b_val;
      OP_ISUB: result = a_val - b_val;
      OP_ILT:  result = DataW'($signed(a_val) < $signed(b_val));
      OP_IAND: result = DataW'((a_val != '0) && (b_val != '0));
      OP_IOR:  result = DataW'((a_val != '0) || (b_val != '0));
      default: result = a_val + b_val;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (dctl.start) state_next = S_DIV;
        else if (print_go) state_next = S_PRINT_READ;
        else state_next = S_RESULT;
      end
      S_DIV: if (div_done) state_next = S_RESULT;
      S_RESULT: state_next = S_RESULT;
      S_PRINT_READ: state_next = S_PRINT_OUT;
      S_PRINT_OUT: state_next = S_PRINT_OUT;
      default: state_next = S_IDLE;
    endcase
    if (out_valid && out_ch.ready) begin
      if (res.last) state_next = S_IDLE;
      else state_next = S_PRINT_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      level <= '0;
      cur_block <= '0;
      ip <= '0;
      written <= '0;
      out_valid <= 1'b0;
      print_left <= '0;
    end else begin
      state <= state_next;
      if (in_ch.valid && in_ch.ready) item <= in_ch.data;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (state == S_EXEC) begin
        out_valid <= 1'b1;
        res.print_valid <= 1'b0;
        res.print_value <= '0;
        res.status <= ST_OK;
        res.last <= 1'b1;
        res.next_block <= cur_block;
        res.next_ip <= ip;
        priority case (item.opcode)
          OP_ILOAD, OP_ICONST: begin
            if (32'(sp) >= STACK_DEPTH) res.status <= ST_OVERFLOW;
            else begin
              stack_mem[SaW'(sp)] <= (item.opcode == OP_ICONST) ? item.immediate
                                     : (var_ok ? var_rd : '0);
              sp <= sp + SpW'(1);
              ip <= ip_inc;
              res.next_ip <= ip_inc;
            end
          end
          OP_ISTORE: begin
            if (sp == '0) res.status <= ST_UNDERFLOW;
            else begin
              sp <= sp - SpW'(1);
              if (vi_in) begin
                var_mem[slot] <= top;
                written[slot] <= 1'b1;
              end
              ip <= ip_inc;
              res.next_ip <= ip_inc;
            end
          end
          OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_ILT, OP_IAND, OP_IOR: begin
            if (sp < SpW'(2)) res.status <= ST_UNDERFLOW;
            else if (item.opcode == OP_IDIV && top == '0) res.status <= ST_DIV_ZERO;
            else begin
              out_valid <= (item.opcode != OP_IMUL) && (item.opcode != OP_IDIV);
              if (item.opcode != OP_IMUL && item.opcode != OP_IDIV)
                stack_mem[SaW'(sp - SpW'(2))] <= result;
              sp <= sp - SpW'(1);
              ip <= ip_inc;
              res.next_ip <= ip_inc;
            end
          end
          OP_INOT: begin
            if (sp == '0) res.status <= ST_UNDERFLOW;
            else begin
              stack_mem[SaW'(sp - SpW'(1))] <= DataW'(top == '0);
              ip <= ip_inc;
              res.next_ip <= ip_inc;
            end
          end
          OP_GOTO: begin
            cur_block <= tgt;
            ip <= '0;
            res.next_block <= tgt;
            res.next_ip <= '0;
          end
          OP_IFFALSE: begin
            if (sp == '0) res.status <= ST_UNDERFLOW;
            else begin
              sp <= sp - SpW'(1);
              if (top == '0) begin
                cur_block <= tgt;
                ip <= '0;
                res.next_block <= tgt;
                res.next_ip <= '0;
              end else begin
                ip <= ip_inc;
                res.next_ip <= ip_inc;
              end
            end
          end
          OP_CALL: begin
            if (sp == '0) res.status <= ST_UNDERFLOW;
            else if (32'(level) >= CALL_DEPTH) res.status <= ST_CALL_DEPTH;
            else begin
              rblk_mem[CdW'(level)] <= cur_block;
              rip_mem[CdW'(level)] <= ip;
              for (int i = 0; i < VAR_COUNT; i++)
                written[SlW'((32'(level) + 1) * VAR_COUNT + i)] <= 1'b0;
              level <= level + LvW'(1);
              sp <= sp - SpW'(1);
              cur_block <= tgt;
              ip <= '0;
              res.next_block <= tgt;
              res.next_ip <= '0;
            end
          end
          OP_RETURN: begin
            if (level == '0) res.status <= ST_CALL_DEPTH;
            else begin
              level <= level - LvW'(1);
              cur_block <= rblk_rd;
              ip <= IpW'((32'(rip_rd) + 32'd1) % BlockLength);
              res.next_block <= rblk_rd;
              res.next_ip <= IpW'((32'(rip_rd) + 32'd1) % BlockLength);
            end
          end
          OP_PRINT: begin
            if (sp == '0) res.status <= ST_UNDERFLOW;
            else if (!top[DataW-1] && (top > 32'(sp - SpW'(1)) || top > 32'(MaxOut)))
              res.status <= ST_UNDERFLOW;
            else begin
              sp <= sp - SpW'(1);
              ip <= ip_inc;
              res.next_ip <= ip_inc;
              if (!top[DataW-1] && top != '0) begin
                out_valid <= 1'b0;
                print_left <= SpW'(top);
              end
            end
          end
          default: begin
            ip <= ip_inc;
            res.next_ip <= ip_inc;
          end
        endcase
      end
      if (state == S_RESULT && !out_valid) begin
        out_valid <= 1'b1;
        if (item.opcode == OP_IMUL) stack_mem[SaW'(sp - SpW'(1))] <= prod;
        else stack_mem[SaW'(sp - SpW'(1))] <= div_q;
      end
      if (state == S_PRINT_OUT && !out_valid) begin
        out_valid <= 1'b1;
        res.print_valid <= 1'b1;
        res.print_value <= top;
        res.last <= (print_left == SpW'(1));
        sp <= sp - SpW'(1);
        print_left <= print_left - SpW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) 32'(sp) <= STACK_DEPTH)
    else $error("stack pointer beyond depth");
  a_level_bound: assert property (@(posedge clk) disable iff (rst) 32'(level) <= CALL_DEPTH)
    else $error("frame level beyond call depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.print_valid) |-> (res.status == ST_OK))
    else $error("printed value with fault status");
`endif

endmodule
